/* hdl/vsd_pkg.sv */
// ----------------------------------------------------------------------------
// vsd_pkg
// Types and constants shared by the similarity/distance controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package vsd_pkg;

   localparam int ELEM_W      = 16;
   localparam int SUM_W       = 44;
   localparam int PROD_W      = 2 * SUM_W;
   localparam int WIDE_W      = 128;
   localparam int RES_W       = 32;
   localparam int Q_W         = 17;
   localparam int ROOT_W      = 26;
   localparam int CNT_W       = 6;
   localparam int MUL_CYCLES  = SUM_W;
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int TOP_BIT     = Q_W - 1;

   localparam logic [1:0] MODE_COSINE = 2'd0;
   localparam logic [1:0] MODE_L2     = 2'd1;

   localparam logic [RES_W-1:0] ONE_Q16 = 32'h0001_0000;

   typedef enum logic [2:0] {
      ST_ACC,
      ST_LOAD,
      ST_MUL,
      ST_INIT,
      ST_SEARCH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mul_step;
      logic       sqrt_step;
      logic       srch_init;
      logic       srch_step;
      logic [4:0] bit_k;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } stat_type;

endpackage

/* hdl/vsd_ctrl.sv */
// ----------------------------------------------------------------------------
// vsd_ctrl
// Sequencer: accumulate, load, serial multiply with root, quotient search,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module vsd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              acc_last,
   input  vsd_pkg::stat_type stat,
   output logic              req_ready,
   output vsd_pkg::cmd_type  cmd
);

   localparam int CNT_W = vsd_pkg::CNT_W;

   vsd_pkg::state_type         state_ff, state_in;
   logic [vsd_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vsd_pkg::ST_ACC;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         vsd_pkg::ST_ACC: begin
            if (acc_last) state_in = vsd_pkg::ST_LOAD;
         end
         vsd_pkg::ST_LOAD: begin
            state_in = vsd_pkg::ST_MUL;
            cnt_in   = '0;
         end
         vsd_pkg::ST_MUL: begin
            if (cnt_ff == CNT_W'(vsd_pkg::MUL_CYCLES - 1)) begin
               state_in = vsd_pkg::ST_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         vsd_pkg::ST_INIT: begin
            state_in = vsd_pkg::ST_SEARCH;
            cnt_in   = CNT_W'(vsd_pkg::TOP_BIT);
         end
         vsd_pkg::ST_SEARCH: begin
            if (cnt_ff == '0) begin
               state_in = vsd_pkg::ST_EMIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         vsd_pkg::ST_EMIT: begin
            if (!stat.out_full) state_in = vsd_pkg::ST_ACC;
         end
         default: state_in = vsd_pkg::ST_ACC;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == vsd_pkg::ST_ACC);
      cmd.load      = (state_ff == vsd_pkg::ST_LOAD);
      cmd.mul_step  = (state_ff == vsd_pkg::ST_MUL);
      cmd.sqrt_step = (state_ff == vsd_pkg::ST_MUL) &&
                      (cnt_ff < CNT_W'(vsd_pkg::SQRT_STEPS));
      cmd.srch_init = (state_ff == vsd_pkg::ST_INIT);
      cmd.srch_step = (state_ff == vsd_pkg::ST_SEARCH);
      cmd.bit_k     = cnt_ff[4:0];
      cmd.emit      = (state_ff == vsd_pkg::ST_EMIT) && !stat.out_full;
   end

endmodule

/* hdl/vsd_datapath.sv */
// ----------------------------------------------------------------------------
// vsd_datapath
// Saturating sums, shift-add multipliers, digit-by-digit root, bit-serial
// quadratic search and the result register.
// ----------------------------------------------------------------------------
module vsd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              acc_valid,
   input  logic signed [vsd_pkg::ELEM_W-1:0] elem_a,
   input  logic signed [vsd_pkg::ELEM_W-1:0] elem_b,
   input  logic [1:0]                        mode,
   input  vsd_pkg::cmd_type                  cmd,
   output vsd_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [vsd_pkg::RES_W-1:0]         similarity,
   output logic [vsd_pkg::RES_W-1:0]         distance,
   output logic                              zero_norm
);

   localparam int SW = vsd_pkg::SUM_W;
   localparam int PW = vsd_pkg::PROD_W;
   localparam int WW = vsd_pkg::WIDE_W;
   localparam int RW = vsd_pkg::RES_W;
   localparam int QW = vsd_pkg::Q_W;
   localparam int TW = vsd_pkg::ROOT_W;
   localparam int XW = SW + 8;

   // sums
   logic signed [SW-1:0] dot_ff;
   logic [SW-1:0]        na_ff, nb_ff, ds_ff;
   logic signed [31:0]   pr, sqa, sqb;
   logic signed [16:0]   dif;
   logic signed [33:0]   dsq;
   logic signed [SW:0]   dot_w;
   logic [SW:0]          na_w, nb_w, ds_w;

   always_comb begin
      pr    = elem_a * elem_b;
      sqa   = elem_a * elem_a;
      sqb   = elem_b * elem_b;
      dif   = 17'(elem_a) - 17'(elem_b);
      dsq   = dif * dif;
      dot_w = {dot_ff[SW-1], dot_ff} + (SW+1)'(pr);
      na_w  = {1'b0, na_ff} + {13'b0, sqa};
      nb_w  = {1'b0, nb_ff} + {13'b0, sqb};
      ds_w  = {1'b0, ds_ff} + {13'b0, dsq[31:0]};
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         dot_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
         ds_ff  <= '0;
      end else if (acc_valid) begin
         if (dot_w[SW] != dot_w[SW-1]) begin
            dot_ff <= dot_w[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
         end else begin
            dot_ff <= dot_w[SW-1:0];
         end
         na_ff <= na_w[SW] ? '1 : na_w[SW-1:0];
         nb_ff <= nb_w[SW] ? '1 : nb_w[SW-1:0];
         ds_ff <= ds_w[SW] ? '1 : ds_w[SW-1:0];
      end
   end

   // captured operands, shift-add multipliers, root
   logic [1:0]    mode_ff;
   logic          neg_ff, zero_ff;
   logic [SW-1:0] dsq_ff;
   logic [PW-1:0] mca_ff, mcd_ff, pa_ff, pd_ff;
   logic [SW-1:0] mla_ff, mld_ff;
   logic [XW-1:0] x_ff;
   logic [TW:0]   rem_ff;
   logic [TW-1:0] root_ff;
   logic [SW-1:0] adot;
   logic [TW+2:0] rem_sh, trial;

   always_comb begin
      adot   = dot_ff[SW-1] ? SW'(-dot_ff) : dot_ff;
      rem_sh = {rem_ff, x_ff[XW-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode;
         neg_ff  <= dot_ff[SW-1];
         zero_ff <= (na_ff == '0) || (nb_ff == '0);
         dsq_ff  <= ds_ff;
         mca_ff  <= {{SW{1'b0}}, na_ff};
         mla_ff  <= nb_ff;
         mcd_ff  <= {{SW{1'b0}}, adot};
         mld_ff  <= adot;
         pa_ff   <= '0;
         pd_ff   <= '0;
         x_ff    <= {ds_ff, 8'b0};
         rem_ff  <= '0;
         root_ff <= '0;
      end else begin
         if (cmd.mul_step) begin
            if (mla_ff[0]) pa_ff <= pa_ff + mca_ff;
            if (mld_ff[0]) pd_ff <= pd_ff + mcd_ff;
            mca_ff <= mca_ff << 1;
            mcd_ff <= mcd_ff << 1;
            mla_ff <= mla_ff >> 1;
            mld_ff <= mld_ff >> 1;
         end
         if (cmd.sqrt_step) begin
            x_ff <= x_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff  <= (TW+1)'(rem_sh - trial);
               root_ff <= {root_ff[TW-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh[TW:0];
               root_ff <= {root_ff[TW-2:0], 1'b0};
            end
         end
      end
   end

   // largest m in [0, 1.0] with c2*m*m + c1*m + c0 <= 0, one bit a cycle
   logic signed [WW-1:0] c2_ff, g_ff, v_ff;
   logic                 lin_ff;
   logic [QW-1:0]        m_ff;
   logic signed [WW-1:0] term, v_t;
   logic [5:0]           k2;
   logic                 take;

   always_comb begin
      k2   = {cmd.bit_k, 1'b0};
      term = (g_ff <<< (cmd.bit_k + 5'd1)) + (c2_ff <<< k2);
      if (lin_ff) term = term + (WW'(1) <<< (6'd41 + 6'(cmd.bit_k)));
      v_t  = v_ff + term;
      take = !m_ff[QW-1] && (v_t[WW-1] || (v_t == '0));
   end

   always_ff @(posedge clock) begin
      if (cmd.srch_init) begin
         g_ff   <= '0;
         m_ff   <= '0;
         lin_ff <= (mode_ff == vsd_pkg::MODE_L2);
         if (mode_ff == vsd_pkg::MODE_L2) begin
            c2_ff <= $signed({{(WW-SW){1'b0}}, dsq_ff}) - (WW'(1) <<< 24);
            v_ff  <= -(WW'(1) <<< 56);
         end else begin
            c2_ff <= $signed({{(WW-PW){1'b0}}, pa_ff});
            v_ff  <= -($signed({{(WW-PW){1'b0}}, pd_ff}) <<< 32);
         end
      end else if (cmd.srch_step && take) begin
         v_ff <= v_t;
         g_ff <= g_ff + (c2_ff <<< cmd.bit_k);
         m_ff <= m_ff | (QW'(1) << cmd.bit_k);
      end
   end

   // result register
   logic [RW-1:0] q, sim_c, dist_c;
   logic          zn_c, exact;
   logic [RW-1:0] sim_ff, dist_ff;
   logic          zn_ff, valid_ff;

   always_comb begin
      q      = RW'(m_ff);
      exact  = m_ff[QW-1] || (v_ff == '0);
      sim_c  = '0;
      dist_c = '0;
      zn_c   = 1'b0;
      case (mode_ff)
         vsd_pkg::MODE_COSINE: begin
            if (zero_ff) begin
               zn_c = 1'b1;
            end else if (neg_ff) begin
               sim_c  = -q;
               dist_c = vsd_pkg::ONE_Q16 + q;
            end else begin
               sim_c  = q;
               dist_c = vsd_pkg::ONE_Q16 - q - {{(RW-1){1'b0}}, !exact};
            end
         end
         vsd_pkg::MODE_L2: begin
            sim_c  = q;
            dist_c = RW'(root_ff);
         end
         default: begin
            sim_c  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         sim_ff  <= sim_c;
         dist_ff <= dist_c;
         zn_ff   <= zn_c;
      end
   end

   assign stat.out_full = valid_ff;
   assign rsp_valid     = valid_ff;
   assign similarity    = sim_ff;
   assign distance      = dist_ff;
   assign zero_norm     = zn_ff;

endmodule

/* hdl/vector_similarity_distance.sv */
// ----------------------------------------------------------------------------
// vector_similarity_distance
// Cosine or l2 similarity and distance of two streamed Q4.12 vectors.
// ----------------------------------------------------------------------------
// Element pairs are taken one word per cycle and summed as they arrive. The
// word flagged tlast closes the vectors: the block then stops taking words
// through the load, the shift-add multipliers that form the norm and dot
// products (with the root of the l2 sum alongside), the set-up, the
// bit-serial quotient search and the write of the result, longer if the
// previous result is still waiting in the output register, and then resumes
// while the new result waits there. Results are signed Q16.16, truncated.
module vector_similarity_distance (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // elem_a[15:0], elem_b[31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // similarity[31:0], distance[63:32]
   output logic        rsp_tuser,   // zero_norm
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic              mode_wr;
   logic [1:0]        mode_ff, mode_in;
   logic              accept;
   vsd_pkg::cmd_type  cmd;
   vsd_pkg::stat_type stat;
   logic [31:0]       sim, dist_val;

   assign csr_pready = 1'b1;
   assign mode_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == 2'b00);
   assign mode_in    = mode_wr ? csr_pwdata[1:0] : mode_ff;
   assign csr_prdata = {30'b0, mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= vsd_pkg::MODE_COSINE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign accept = req_tvalid && req_tready;

   vsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .acc_last  (accept && req_tlast),
      .stat      (stat),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   vsd_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .acc_valid  (accept),
      .elem_a     (req_tdata[15:0]),
      .elem_b     (req_tdata[31:16]),
      .mode       (mode_ff),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .similarity (sim),
      .distance   (dist_val),
      .zero_norm  (rsp_tuser)
   );

   assign rsp_tdata = {dist_val, sim};

endmodule

/* hdl/vsd_checker.sv */
// ----------------------------------------------------------------------------
// vsd_checker
// Port-level checks on the similarity/distance block.
// ----------------------------------------------------------------------------
module vsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   // closing word starts the finishing run, which drops req_tready
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("word taken straight after closing word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   a_zero_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("zero norm with non-zero values");

   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result written while input side open");

endmodule

bind vector_similarity_distance vsd_checker u_vsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* verif/vector_similarity_distance_tb.sv */
// ----------------------------------------------------------------------------
// vector_similarity_distance_tb
// Streams element pairs through the cosine/l2 unit in every measure mode,
// predicts each Q16.16 result and checks it against the rsp channel under
// random source gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
   logic [31:0] sim;
   logic [31:0] distance_q;
   logic        zero_norm;
} score_type;

class similarity_checker;
   localparam longint DOT_MAX  = 64'sd8796093022207;
   localparam longint DOT_MIN  = -64'sd8796093022208;
   localparam longint USUM_MAX = 64'sd17592186044415;

   longint dot_acc, norm_a_acc, norm_b_acc, diff_acc;
   logic [1:0] mode;
   score_type pending_scores[$];
   int mismatches;

   function new();
      dot_acc = 0; norm_a_acc = 0; norm_b_acc = 0; diff_acc = 0;
      mode = vsd_pkg::MODE_COSINE;
      mismatches = 0;
   endfunction

   function longint usat(longint s, longint p);
      return (p > USUM_MAX - s) ? USUM_MAX : s + p;
   endfunction

   function longint root_floor(longint x);
      longint lo, hi, mid;
      lo = 0; hi = 64'd67108864;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= x) lo = mid; else hi = mid - 1;
      end
      return lo;
   endfunction

   function void note_word(logic signed [15:0] ea, logic signed [15:0] eb, logic last);
      longint sa, sb, dd, pr, q, lo, hi, mid, adot, sim_v, dist_v;
      logic [127:0] p, rhs, m, t, w;
      logic neg, exact;
      score_type s;
      sa = ea; sb = eb; dd = sa - sb; pr = sa * sb;
      if (pr > 0 && dot_acc > DOT_MAX - pr) dot_acc = DOT_MAX;
      else if (pr < 0 && dot_acc < DOT_MIN - pr) dot_acc = DOT_MIN;
      else dot_acc += pr;
      norm_a_acc = usat(norm_a_acc, sa * sa);
      norm_b_acc = usat(norm_b_acc, sb * sb);
      diff_acc   = usat(diff_acc, dd * dd);
      if (!last) return;
      sim_v = 0; dist_v = 0; s.zero_norm = 1'b0;
      if (mode == vsd_pkg::MODE_COSINE) begin
         if (norm_a_acc == 0 || norm_b_acc == 0) begin
            s.zero_norm = 1'b1;
         end else begin
            neg = dot_acc < 0;
            adot = neg ? -dot_acc : dot_acc;
            p = 128'(norm_a_acc) * 128'(norm_b_acc);
            w = 128'(adot);
            rhs = (w * w) << 32;
            lo = 0; hi = 65536;
            while (lo < hi) begin
               mid = (lo + hi + 1) / 2;
               m = 128'(mid);
               if (p * m * m <= rhs) lo = mid; else hi = mid - 1;
            end
            m = 128'(lo);
            exact = (lo == 65536) || (p * m * m == rhs);
            q = lo;
            if (neg) begin
               sim_v = -q; dist_v = 65536 + q;
            end else begin
               sim_v = q; dist_v = 65536 - q - (exact ? 0 : 1);
            end
         end
      end else if (mode == vsd_pkg::MODE_L2) begin
         dist_v = root_floor(diff_acc << 8);
         lo = 0; hi = 65536;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 128'((64'd1 << 28) - 4096 * mid);
            m = 128'(mid);
            if (m * m * 128'(diff_acc) <= t * t) lo = mid; else hi = mid - 1;
         end
         sim_v = lo;
      end
      s.sim = sim_v[31:0];
      s.distance_q = dist_v[31:0];
      pending_scores = {pending_scores, s};
      dot_acc = 0; norm_a_acc = 0; norm_b_acc = 0; diff_acc = 0;
   endfunction

   function void check_result(logic [31:0] sim, logic [31:0] distance_q, logic zn);
      score_type e;
      if (pending_scores.size() == 0) begin
         $display("%0t: unexpected result sim=%h dist=%h zn=%b", $time, sim, distance_q, zn);
         mismatches++;
         return;
      end
      e = pending_scores.pop_front();
      if (sim !== e.sim) begin
         $display("%0t: similarity exp %h got %h", $time, e.sim, sim);
         mismatches++;
      end
      if (distance_q !== e.distance_q) begin
         $display("%0t: distance exp %h got %h", $time, e.distance_q, distance_q);
         mismatches++;
      end
      if (zn !== e.zero_norm) begin
         $display("%0t: zero_norm exp %b got %b", $time, e.zero_norm, zn);
         mismatches++;
      end
   endfunction
endclass

module vector_similarity_distance_tb;

   localparam int CYCLE_LIMIT = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   similarity_checker checker_h = new();
   int send_idle_pct = 0;
   int sink_stall_pct = 0;
   int sink_hold = 0;
   int cycle_count = 0;

   vector_similarity_distance DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            checker_h.note_word(req_tdata[15:0], req_tdata[31:16], req_tlast);
         if (rsp_tvalid && rsp_tready)
            checker_h.check_result(rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
      end
   end

   task automatic send_word(logic [15:0] ea, logic [15:0] eb, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {eb, ea};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_mode(logic [1:0] m);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= '0; csr_pwdata <= 32'(m);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      checker_h.mode = m;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (checker_h.pending_scores.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // one vector pair; style picks the relation between a and b
   task automatic send_vector(int len, int style);
      logic [15:0] ea, eb;
      for (int i = 0; i < len; i++) begin
         ea = 16'($urandom);
         if (style == 1) ea = 16'($signed($urandom_range(64)) - 32);
         eb = 16'($urandom);
         case (style)
            2: eb = ea;
            3: eb = -ea;
            4: ea = '0;
            default: ;
         endcase
         send_word(ea, eb, i == len - 1);
      end
   endtask

   task automatic directed();
      send_word(16'h8000, 16'h8000, 1'b1);
      send_word(16'h7fff, 16'h8000, 1'b1);
      send_word(16'h0000, 16'h1000, 1'b1);
      send_word(16'h1000, 16'h0000, 1'b1);
      send_word(16'h0000, 16'h0000, 1'b1);
      send_word(16'h1000, 16'h1000, 1'b0);
      send_word(16'h2000, 16'h2000, 1'b1);
      send_word(16'h7fff, 16'h8001, 1'b0);
      send_word(16'h0001, 16'hffff, 1'b1);
      send_word(16'h7fff, 16'h7fff, 1'b0);
      send_word(16'h8000, 16'h7fff, 1'b1);
      send_word(16'h0001, 16'h0002, 1'b1);
   endtask

   initial begin
      int len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int m = 0; m < 4; m++) begin
         write_mode(2'(m));
         directed();
         drain();
      end
      for (int ph = 0; ph < 8; ph++) begin
         write_mode(2'(ph % 4));
         case (ph % 4)
            0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin send_idle_pct = 65; sink_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  sink_stall_pct = 65; end
            default: begin send_idle_pct = 25; sink_stall_pct = 25; end
         endcase
         if (ph == 4) sink_hold = 2000;
         for (int n = 0; n < 230; n += len) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
            send_vector(len, $urandom_range(9) < 5 ? 0 : $urandom_range(4, 1));
         end
         drain();
      end
      if (checker_h.mismatches == 0 && checker_h.pending_scores.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

/* sim.f */
hdl/vsd_pkg.sv
hdl/vsd_ctrl.sv
hdl/vsd_datapath.sv
hdl/vector_similarity_distance.sv
hdl/vsd_checker.sv
verif/vector_similarity_distance_tb.sv
